// ===== src/rgbyuv_pkg.sv =====
// Shared constants, types and helper functions for the RGB to YCbCr 4:2:0 converter.
// Used by rgb_to_yuv420_converter_core; depends on nothing else.
`timescale 1ns / 1ps

package rgbyuv_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int LINE_DEPTH   = MAX_WIDTH / 2;
	localparam int SLOT_W       = $clog2(LINE_DEPTH);
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int DIM_W        = 13;
	localparam int PAIR_W       = 9;
	localparam int TOT_W        = 10;
	localparam int LUMA_ACC_W   = 16;
	localparam int CHROMA_ACC_W = 19;
	localparam int ADDR_W       = 3;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;
	localparam logic [DIM_W-1:0] WIDTH_TOP    = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_TOP   = DIM_W'(HEIGHT_LIMIT);

	// BT.601 coefficients; chroma coefficients are stored as magnitudes.
	localparam logic [LUMA_ACC_W-1:0] Y_R      = 16'd66;
	localparam logic [LUMA_ACC_W-1:0] Y_G      = 16'd129;
	localparam logic [LUMA_ACC_W-1:0] Y_B      = 16'd25;
	localparam logic [LUMA_ACC_W-1:0] Y_ROUND_BIAS = 16'd4224;
	localparam logic [CHROMA_ACC_W-1:0] CB_R     = 19'd38;
	localparam logic [CHROMA_ACC_W-1:0] CB_G     = 19'd74;
	localparam logic [CHROMA_ACC_W-1:0] CB_B     = 19'd112;
	localparam logic [CHROMA_ACC_W-1:0] CR_R     = 19'd112;
	localparam logic [CHROMA_ACC_W-1:0] CR_G     = 19'd94;
	localparam logic [CHROMA_ACC_W-1:0] CR_B     = 19'd18;
	localparam logic [CHROMA_ACC_W-1:0] C_OFFSET = 19'd131584;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Same layout as one line store entry: red in the top bits, blue at the bottom.
	typedef struct packed {
		logic [PAIR_W-1:0] r;
		logic [PAIR_W-1:0] g;
		logic [PAIR_W-1:0] b;
	} pair_sum_t;

	// Even part of a dimension register, held between 2 and the given top.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] top);
		logic [DIM_W-1:0] e;
		e = {v[DIM_W-1:1], 1'b0};
		if (e < DIM_W'(2)) begin
			e = DIM_W'(2);
		end
		if (e > top) begin
			e = top;
		end
		return e;
	endfunction

	function automatic logic [7:0] luma_of(input logic [23:0] px);
		logic [LUMA_ACC_W-1:0] acc;
		acc = Y_R * {8'b0, px[23:16]} + Y_G * {8'b0, px[15:8]}
			+ Y_B * {8'b0, px[7:0]} + Y_ROUND_BIAS;
		return acc[15:8];
	endfunction

endpackage

// ===== src/rgb_to_yuv420_converter_core.sv =====
// Top level of the RGB to YCbCr 4:2:0 stream converter with its line store.
// Depends on rgbyuv_pkg for constants, types and the luma function.
`timescale 1ns / 1ps

// The core takes one BGRA pixel per clock in raster order and returns one item per pixel:
// the pixel's BT.601 luma and, on the bottom-right pixel of every 2x2 block (odd row, odd
// column), the block's Cb and Cr with chroma_valid set. frame_end (tlast) marks the last
// pixel of the frame. Sustained rate is one pixel per cycle while m_tready is high; a
// pixel's item passes through stage 1, stage 2 and the output register. The single line
// store is read or written once per column pair: the even row writes the pair sums of
// each column pair, the odd row reads them back, and since a write always lands at least
// one row before the read of the same entry, no forwarding is needed. The line store is
// not cleared after reset; every entry is written before it is read within a frame. The
// user must write frame_width and frame_height through the APB port only while the stream
// is idle; the block does not enforce this. Even parts are used, held between 2 and 4096.
module rgb_to_yuv420_converter_core import rgbyuv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel input.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // pixel_word[31:0]
	// Result output.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // luma[7:0], blue_diff[15:8], red_diff[23:16]
	output logic [0:0]        m_tuser,   // chroma_valid[0]
	output logic              m_tlast,   // frame_end
	// Configuration.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [23:0]      left_hold_q;
	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;

	logic             accept;
	logic             advance;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;
	logic             row_end;
	logic             frame_last;
	logic             col_odd;
	logic             row_odd;
	logic [SLOT_W-1:0] slot;
	pair_sum_t        pair_now;
	cfg_reg_t         cfg_sel;

	// Line store of even-row pair sums.
	pair_sum_t        line_mem [LINE_DEPTH];
	pair_sum_t        line_rd_s1;

	logic             v_s1;
	logic [23:0]      px_s1;
	pair_sum_t        pair_s1;
	logic             chroma_s1;
	logic             last_s1;

	logic             v_s2;
	logic [23:0]      px_s2;
	logic [TOT_W-1:0] tot_r_s2;
	logic [TOT_W-1:0] tot_g_s2;
	logic [TOT_W-1:0] tot_b_s2;
	logic             chroma_s2;
	logic             last_s2;

	logic             out_valid_q;
	logic [7:0]       luma_q;
	logic [7:0]       cb_q;
	logic [7:0]       cr_q;
	logic             chroma_q;
	logic             last_q;

	logic [CHROMA_ACC_W-1:0] u_acc;
	logic [CHROMA_ACC_W-1:0] v_acc;

	// ---------------------------------------------------------------- configuration
	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_sel)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_FRAME_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, frame_height_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- input position
	// The whole pipeline moves as one whenever the output register can take an item.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && s_tready;

	assign width_eff  = clamp_dim(frame_width_q, WIDTH_TOP);
	assign height_eff = clamp_dim(frame_height_q, HEIGHT_TOP);
	assign row_end    = {1'b0, column_q} >= (width_eff - DIM_W'(1));
	assign frame_last = row_end && ({1'b0, row_q} >= (height_eff - DIM_W'(1)));
	assign col_odd    = column_q[0];
	assign row_odd    = row_q[0];
	assign slot       = column_q[COL_W-1:1];

	assign pair_now.r = {1'b0, left_hold_q[23:16]} + {1'b0, s_tdata[23:16]};
	assign pair_now.g = {1'b0, left_hold_q[15:8]} + {1'b0, s_tdata[15:8]};
	assign pair_now.b = {1'b0, left_hold_q[7:0]} + {1'b0, s_tdata[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hold_q <= '0;
			column_q    <= '0;
			row_q       <= '0;
		end else if (accept) begin
			if (!col_odd) begin
				left_hold_q <= s_tdata[23:0];
			end
			if (row_end) begin
				column_q <= '0;
				row_q    <= frame_last ? '0 : row_q + ROW_W'(1);
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- line store
	// Even rows write the pair sums at the odd column; odd rows read them back there.
	always_ff @(posedge clk) begin
		if (accept && col_odd) begin
			if (!row_odd) begin
				line_mem[slot] <= pair_now;
			end else begin
				line_rd_s1 <= line_mem[slot];
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1     <= s_tdata[23:0];
			pair_s1   <= pair_now;
			chroma_s1 <= col_odd && row_odd;
			last_s1   <= frame_last;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Four-pixel channel totals of the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			px_s2     <= px_s1;
			tot_r_s2  <= {1'b0, pair_s1.r} + {1'b0, line_rd_s1.r};
			tot_g_s2  <= {1'b0, pair_s1.g} + {1'b0, line_rd_s1.g};
			tot_b_s2  <= {1'b0, pair_s1.b} + {1'b0, line_rd_s1.b};
			chroma_s2 <= chroma_s1;
			last_s2   <= last_s1;
		end
	end

	// ---------------------------------------------------------------- output register
	// Both chroma sums stay within 0 to 2^18 for any totals up to 1020, so the
	// negative terms can be subtracted modulo 2^19 with no sign handling.
	always_comb begin
		u_acc = C_OFFSET + CB_B * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_b_s2}
			- CB_R * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_r_s2}
			- CB_G * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_g_s2};
		v_acc = C_OFFSET + CR_R * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_r_s2}
			- CR_G * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_g_s2}
			- CR_B * {{(CHROMA_ACC_W-TOT_W){1'b0}}, tot_b_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2) begin
			luma_q   <= luma_of(px_s2);
			cb_q     <= chroma_s2 ? u_acc[17:10] : 8'd0;
			cr_q     <= chroma_s2 ? v_acc[17:10] : 8'd0;
			chroma_q <= chroma_s2;
			last_q   <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {cr_q, cb_q, luma_q};
	assign m_tuser  = chroma_q;
	assign m_tlast  = last_q;

	// ---------------------------------------------------------------- assertions
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_last |=> column_q == '0 && row_q == '0)
		else $error("position did not return to the frame origin after the last pixel");

	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:8] == 16'd0)
		else $error("chroma fields nonzero on an item without a finished block");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end && !frame_last |=> row_q == $past(row_q) + ROW_W'(1))
		else $error("row count did not step at the end of a row");

endmodule

// ===== tb/sv/rgb_to_yuv420_converter_core_tb.sv =====
// Self-checking testbench for rgb_to_yuv420_converter_core: random pixel streams, frame
// sizes and stalls, checked against a BT.601 4:2:0 conversion model kept in this file.
// Depends on rgbyuv_pkg and rgb_to_yuv420_converter_core.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_core_tb;
	import rgbyuv_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RANDOM_PIXELS = 1350;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// Pixels pass stage 1, stage 2 and the output register; the tail wait leaves margin.
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_PAUSE     = 11;
	localparam int FRAME_CHUNK   = 200;
	localparam int LUMA_OFFSET   = 128 + (16 << 8);
	localparam int CHROMA_OFFSET = 512 + (128 << 10);

	// One output item, with the fields it carries.
	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_ok;
		logic [7:0] cb;
		logic [7:0] cr;
		logic       last;
	} yuv_item_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [23:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	rgb_to_yuv420_converter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Pixels waiting to be offered, and the output items the conversion model expects.
	logic [31:0] pixel_backlog[$];
	yuv_item_t   pending_yuv[$];
	int          mismatches = 0;

	// Handshake bookkeeping shared between the rising-edge monitor and the
	// falling-edge drivers. driving, gap_left and stall_left are written on both edges.
	bit idle_on    = 1'b1;
	bit driving    = 1'b0;
	int gap_left   = 0;
	int stall_left = 0;

	// Conversion model state: its own copy of the registers, the line of even-row
	// pair sums, the held even-column pixel and the raster position.
	logic [12:0] width_reg  = WIDTH_RESET;
	logic [12:0] height_reg = HEIGHT_RESET;
	logic [23:0] held_pixel = '0;
	int          col_pos    = 0;
	int          row_pos    = 0;
	logic [26:0] pair_line[LINE_DEPTH];
	// Marks line entries written since reset; the core's line store is undefined
	// before that, so the stimulus never lets an odd row read an unmarked entry.
	bit          pair_seen[LINE_DEPTH];

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// A dimension register counts by its even part, held between 2 and the top.
	function automatic int even_dim(input logic [12:0] value, input int top);
		int e;
		e = int'(value) & ~1;
		if (e < 2) begin
			e = 2;
		end
		if (e > top) begin
			e = top;
		end
		return e;
	endfunction

	function automatic int pause_cycles();
		return idle_on ? int'($urandom_range(0, MAX_PAUSE)) : 0;
	endfunction

	// Mostly full-range words, now and then all zeros or all ones.
	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Pixels still to come before the current frame ends under the present sizes.
	// A column at or past the last one ends the row with the next pixel.
	function automatic int pixels_to_frame_end();
		int w;
		int h;
		int row_rest;
		w = even_dim(width_reg, MAX_WIDTH);
		h = even_dim(height_reg, HEIGHT_LIMIT);
		row_rest = (col_pos >= w - 1) ? 1 : w - col_pos;
		if (row_pos >= h - 1) begin
			return row_rest;
		end
		return row_rest + (h - 1 - row_pos) * w;
	endfunction

	// A new width is harmless on an even row, since that row writes every entry the
	// next odd row reads. On an odd row every entry still to be read must already
	// hold data.
	function automatic bit width_keeps_line_defined(input int w);
		int lo;
		int hi;
		if (row_pos % 2 == 0) begin
			return 1'b1;
		end
		lo = col_pos >> 1;
		hi = w / 2 - 1;
		if (col_pos % 2 == 1 && hi < lo) begin
			hi = lo;
		end
		for (int s = lo; s <= hi; s++) begin
			if (!pair_seen[s]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Converts one accepted pixel and queues the item the core must return for it.
	task automatic convert_pixel(input logic [31:0] word);
		int        w;
		int        h;
		int        slot;
		bit        row_end;
		bit        last_px;
		int        sr;
		int        sg;
		int        sb;
		int        tr;
		int        tg;
		int        tb;
		int        u;
		int        v;
		yuv_item_t item;
		w = even_dim(width_reg, MAX_WIDTH);
		h = even_dim(height_reg, HEIGHT_LIMIT);
		slot = col_pos >> 1;
		if (slot > LINE_DEPTH - 1) begin
			slot = LINE_DEPTH - 1;
		end
		row_end = col_pos >= w - 1;
		last_px = row_end && row_pos >= h - 1;
		item = '0;
		item.luma = 8'((66 * int'(word[23:16]) + 129 * int'(word[15:8])
			+ 25 * int'(word[7:0]) + LUMA_OFFSET) >> 8);
		if (col_pos % 2 == 0) begin
			held_pixel = word[23:0];
		end else begin
			sr = int'(held_pixel[23:16]) + int'(word[23:16]);
			sg = int'(held_pixel[15:8]) + int'(word[15:8]);
			sb = int'(held_pixel[7:0]) + int'(word[7:0]);
			if (row_pos % 2 == 0) begin
				pair_line[slot] = {9'(sr), 9'(sg), 9'(sb)};
				pair_seen[slot] = 1'b1;
			end else begin
				// Odd row: add the even row's pair sums to get the 2x2 totals.
				tr = sr + int'(pair_line[slot][26:18]);
				tg = sg + int'(pair_line[slot][17:9]);
				tb = sb + int'(pair_line[slot][8:0]);
				u = -38 * tr - 74 * tg + 112 * tb + CHROMA_OFFSET;
				v = 112 * tr - 94 * tg - 18 * tb + CHROMA_OFFSET;
				item.chroma_ok = 1'b1;
				item.cb = 8'(u >> 10);
				item.cr = 8'(v >> 10);
			end
		end
		item.last = last_px;
		pending_yuv.push_back(item);
		if (row_end) begin
			col_pos = 0;
			row_pos = last_px ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	// Rising edge: take accepted pixels into the model and check accepted items
	// against the oldest expectation.
	always @(posedge clk) begin
		yuv_item_t want;
		yuv_item_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				convert_pixel(s_tdata);
				driving = 1'b0;
				gap_left = pause_cycles();
			end
			if (m_tvalid && m_tready) begin
				got.luma = m_tdata[7:0];
				got.cb = m_tdata[15:8];
				got.cr = m_tdata[23:16];
				got.chroma_ok = m_tuser[0];
				got.last = m_tlast;
				if (pending_yuv.size() == 0) begin
					$error("unexpected output item: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = pending_yuv.pop_front();
					if (got.luma !== want.luma) begin
						$error("luma: expected %0d, got %0d", want.luma, got.luma);
						mismatches++;
					end
					if (got.chroma_ok !== want.chroma_ok) begin
						$error("chroma_valid: expected %0d, got %0d",
							want.chroma_ok, got.chroma_ok);
						mismatches++;
					end
					if (got.cb !== want.cb) begin
						$error("blue_diff: expected %0d, got %0d", want.cb, got.cb);
						mismatches++;
					end
					if (got.cr !== want.cr) begin
						$error("red_diff: expected %0d, got %0d", want.cr, got.cr);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$error("frame_end: expected %0d, got %0d", want.last, got.last);
						mismatches++;
					end
				end
				stall_left = pause_cycles();
			end
		end
	end

	// Falling edge: the pixel source. After each accepted pixel it waits the drawn
	// number of cycles, then offers the next one and holds it until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!driving && pixel_backlog.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					s_tdata <= pixel_backlog.pop_front();
					driving = 1'b1;
				end
			end
			s_tvalid <= driving;
		end
	end

	// Falling edge: the item sink, holding tready low for the drawn stall after
	// each accepted item.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Writes a register through the APB port, with random bits above the 13 that
	// count, then reads it back and checks the stored value.
	task automatic program_register(input cfg_reg_t which, input logic [12:0] value);
		logic [31:0] word;
		word = $urandom();
		word[12:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(which));
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (which == REG_FRAME_WIDTH) begin
			width_reg = value;
		end else begin
			height_reg = value;
		end
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(value)) begin
			$error("prdata of register %s: expected %0d, got %0d",
				which.name(), value, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_sizes(input logic [12:0] w, input logic [12:0] h);
		program_register(REG_FRAME_WIDTH, w);
		program_register(REG_FRAME_HEIGHT, h);
	endtask

	// Waits until every pixel is taken and every expected item has come back.
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || driving || pending_yuv.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic stream_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			pixel_backlog.push_back(random_pixel());
		end
		wait_idle();
	endtask

	// Dimension values: mostly small frames, some medium, now and then the edges
	// of the 13-bit register, including the values that clamp.
	function automatic logic [12:0] pick_dim();
		logic [12:0] edge_values[10];
		edge_values = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4094, 13'd4095, 13'd4096,
			13'd4097, 13'd8190, 13'd8191};
		case ($urandom_range(0, 9))
			0: return edge_values[$urandom_range(0, 9)];
			1: return 13'($urandom());
			2, 3: return 13'($urandom_range(25, 300));
			default: return 13'($urandom_range(0, 24));
		endcase
	endfunction

	// Pure channels, extremes and a mid grey for the first frame.
	logic [31:0] corner_pixels[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000,
		32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FFFF, 32'h7F80_8180};

	// Timeout: a correct run ends far below this count.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int random_sent;
		int count;
		logic [12:0] new_width;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames. A 4x2 frame of channel extremes gives two chroma blocks,
		// then the register values 0, 1 and 3 all fall back to 2x2 frames.
		load_sizes(13'd4, 13'd2);
		foreach (corner_pixels[i]) begin
			pixel_backlog.push_back(corner_pixels[i]);
		end
		wait_idle();
		load_sizes(13'd0, 13'd1);
		stream_pixels(4);
		load_sizes(13'd1, 13'd0);
		stream_pixels(4);
		load_sizes(13'd3, 13'd3);
		stream_pixels(4);

		// A width clamped from 8191 keeps the first row going well past its low
		// bits, then a width of 2 ends that row at once. A height clamped from 8191
		// likewise runs 30 rows before a height of 2 ends the frame. These run
		// without idling to keep the run short.
		idle_on = 1'b0;
		load_sizes(13'd8191, 13'd2);
		stream_pixels(40);
		program_register(REG_FRAME_WIDTH, 13'd2);
		stream_pixels(pixels_to_frame_end());
		load_sizes(13'd2, 13'd8191);
		stream_pixels(60);
		program_register(REG_FRAME_HEIGHT, 13'd2);
		stream_pixels(pixels_to_frame_end());
		idle_on = 1'b1;

		// Width shrunk mid-row on an odd row: the pixel at the new last column ends
		// the row, and the frame then goes on with the narrower rows.
		load_sizes(13'd6, 13'd4);
		stream_pixels(9);
		program_register(REG_FRAME_WIDTH, 13'd4);
		stream_pixels(pixels_to_frame_end());

		// Random phases. Each may rewrite either register, frame position kept, then
		// sends either the rest of the frame or a short burst.
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 2) == 0) begin
				new_width = pick_dim();
				if (width_keeps_line_defined(even_dim(new_width, MAX_WIDTH))) begin
					program_register(REG_FRAME_WIDTH, new_width);
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				program_register(REG_FRAME_HEIGHT, pick_dim());
			end
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 1) == 0) begin
				count = pixels_to_frame_end();
				if (count > FRAME_CHUNK) begin
					count = FRAME_CHUNK;
				end
			end else begin
				count = $urandom_range(1, 60);
			end
			stream_pixels(count);
			random_sent += count;
		end

		// Let any stray item show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_yuv.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/rgbyuv_pkg.sv
src/rgb_to_yuv420_converter_core.sv
tb/sv/rgb_to_yuv420_converter_core_tb.sv
